/* design/tmlf_pkg.sv */
// ----------------------------------------------------------------------------
// tmlf_pkg: shared types and constants for the trimmed mean level filter
// Field widths, register map, and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tmlf_pkg;

  // Field widths
  localparam int CH_W      = 2;
  localparam int LVL_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Register map: one height and one override register per tank
  localparam int REG_SETS    = 3;
  localparam int REG_HEIGHT0 = 0;
  localparam int REG_FAKE0   = 3;

  // Average is valid only with more than this many nonzero samples
  localparam int MIN_COUNT = 5;

  localparam logic [LVL_W-1:0] LVL_MAX = 16'hFFFF;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted request
    logic commit;     // write level into the ring, start a new scan
    logic scan;       // issue one ring read
    logic div_start;  // launch the divider
    logic out_load;   // fill the output register
  } tmlf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ch_ok;      // captured channel has its own state and registers
    logic scan_last;  // this read is the oldest entry of the window
    logic enough;     // nonzero sample count gives a valid average
    logic div_done;   // quotient ready
    logic out_free;   // output register empty or being drained
  } tmlf_sts_t;

endpackage

`default_nettype wire

/* design/tmlf_div.sv */
// ----------------------------------------------------------------------------
// tmlf_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle. The remainder never
// reaches the divisor, so it stays D_W bits wide.
// ----------------------------------------------------------------------------
`default_nettype none

module tmlf_div #(
  parameter int N_W = 19,
  parameter int D_W = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] numer,
  input  wire logic [D_W-1:0] denom,
  output logic                done,
  output logic [N_W-1:0]      quot
);

  localparam int NP_W  = N_W + (N_W % 2);
  localparam int STEPS = NP_W / 2;
  localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic            busy;
  logic [SC_W-1:0] step_cnt;
  logic [D_W-1:0]  rem;
  logic [D_W-1:0]  den;
  logic [NP_W-1:0] qsh;
  logic [D_W-1:0]  rem_next;
  logic [NP_W-1:0] qsh_next;

  // Two restoring steps per cycle
  always_comb begin
    logic [D_W:0]    t;
    logic [D_W-1:0]  r;
    logic [NP_W-1:0] q;
    r = rem;
    q = qsh;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[NP_W-1]};
      if (t >= {1'b0, den}) begin
        r = D_W'(t - {1'b0, den});
        q = {q[NP_W-2:0], 1'b1};
      end else begin
        r = t[D_W-1:0];
        q = {q[NP_W-2:0], 1'b0};
      end
    end
    rem_next = r;
    qsh_next = q;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= SC_W'(STEPS - 1);
      end else if (busy) begin
        if (step_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt - 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      qsh <= NP_W'(numer);
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      qsh <= qsh_next;
      rem <= rem_next;
    end
  end

  assign quot = qsh[N_W-1:0];

endmodule

`default_nettype wire

/* design/tmlf_datapath.sv */
// ----------------------------------------------------------------------------
// tmlf_datapath: level computation, sample rings and trimmed mean
// Holds the config registers, per-channel ring memory with valid bits,
// window accumulators, the divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmlf_datapath #(
  parameter int RING_DEPTH = 10,
  parameter int WINDOW     = 7,
  parameter int CHANNELS   = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire tmlf_pkg::tmlf_cmd_t             cmd,
  output tmlf_pkg::tmlf_sts_t                  sts,
  input  wire logic [tmlf_pkg::CH_W-1:0]       in_channel,
  input  wire logic                            in_sensor_ok,
  input  wire logic [tmlf_pkg::LVL_W-1:0]      in_distance,
  input  wire logic                            cfg_we,
  input  wire logic [tmlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmlf_pkg::LVL_W-1:0]      cfg_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [2*tmlf_pkg::LVL_W-1:0]         m_tdata,
  output logic [tmlf_pkg::CH_W+1:0]            m_tuser
);

  localparam int LVL_W     = tmlf_pkg::LVL_W;
  localparam int CH_W      = tmlf_pkg::CH_W;
  localparam int WIN_EFF   = (WINDOW > RING_DEPTH) ? RING_DEPTH : WINDOW;
  localparam int CI_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
  localparam int MA_W      = $clog2(MEM_DEPTH);
  localparam int K_W       = $clog2(WIN_EFF);
  localparam int CNT_W     = $clog2(WIN_EFF + 1);
  localparam int SUM_W     = LVL_W + CNT_W;
  localparam logic [MA_W-1:0]  RD_M     = MA_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  // Config registers
  logic [LVL_W-1:0] height [tmlf_pkg::REG_SETS];
  logic [LVL_W-1:0] fake   [tmlf_pkg::REG_SETS];

  // Per-channel state
  logic [PTR_W-1:0] wp_tab     [CHANNELS];
  logic [LVL_W-1:0] last_lvl   [CHANNELS];
  logic [LVL_W-1:0] stored_avg [CHANNELS];
  logic [MEM_DEPTH-1:0] vbit;
  logic [LVL_W-1:0] ring_mem [MEM_DEPTH];

  // Current request
  logic [CH_W-1:0]  ch_r;
  logic             ok_r;
  logic [LVL_W-1:0] dist_r;
  logic [LVL_W-1:0] level_r;
  logic             lvl_chg_r;

  // Scan and accumulate
  logic [PTR_W-1:0] rd_idx;
  logic [K_W-1:0]   scan_k;
  logic             rd_pend;
  logic [LVL_W-1:0] rd_data;
  logic             rd_vld;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;
  logic [LVL_W-1:0] hi;
  logic [LVL_W-1:0] lo;

  logic [CI_W-1:0]  ci;
  logic [1:0]       rs;
  logic [LVL_W-1:0] level;
  logic [PTR_W-1:0] wp_cur;
  logic [PTR_W-1:0] wp_next;
  logic [PTR_W-1:0] rd_prev;
  logic [MA_W-1:0]  base;
  logic [MA_W-1:0]  wr_addr;
  logic [MA_W-1:0]  rd_addr;
  logic [LVL_W-1:0] smp;
  logic [SUM_W-1:0] numer;
  logic [SUM_W-1:0] quot;
  logic             div_done;
  logic             enough;
  logic [LVL_W-1:0] avg_now;
  logic             chg_now;

  assign ci = CI_W'(ch_r);
  assign rs = ch_r;

  // Instant level: override, clamped difference, or zero on failure
  always_comb begin
    if (fake[rs] != '0) begin
      level = fake[rs];
    end else if (!ok_r || (dist_r > height[rs])) begin
      level = '0;
    end else begin
      level = height[rs] - dist_r;
    end
  end

  // Ring addressing
  assign wp_cur  = wp_tab[ci];
  assign wp_next = (wp_cur == PTR_LAST) ? '0 : wp_cur + 1'b1;
  assign rd_prev = (rd_idx == '0) ? PTR_LAST : rd_idx - 1'b1;
  assign base    = MA_W'(ci) * RD_M;
  assign wr_addr = base + MA_W'(wp_cur);
  assign rd_addr = base + MA_W'(rd_prev);

  assign smp    = rd_vld ? rd_data : '0;
  assign enough = 32'(cnt) > tmlf_pkg::MIN_COUNT;
  assign numer  = sum - SUM_W'(hi) - SUM_W'(lo);

  assign avg_now = enough ? quot[LVL_W-1:0] : '0;
  assign chg_now = lvl_chg_r || (enough && (avg_now != stored_avg[ci]));

  // Status
  always_comb begin
    sts.ch_ok     = (32'(ch_r) < CHANNELS) && (32'(ch_r) < tmlf_pkg::REG_SETS);
    sts.scan_last = (scan_k == K_W'(WIN_EFF - 1));
    sts.enough    = enough;
    sts.div_done  = div_done;
    sts.out_free  = !m_tvalid || m_tready;
  end

  // Config register writes; unknown indexes do nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tmlf_pkg::REG_SETS; i++) begin
        height[i] <= '0;
        fake[i]   <= '0;
      end
    end else if (cfg_we) begin
      if (32'(cfg_index) < tmlf_pkg::REG_FAKE0) begin
        height[2'(cfg_index)] <= cfg_data;
      end else if (32'(cfg_index) < tmlf_pkg::REG_FAKE0 + tmlf_pkg::REG_SETS) begin
        fake[2'(cfg_index - tmlf_pkg::CFG_IDX_W'(tmlf_pkg::REG_FAKE0))] <= cfg_data;
      end
    end
  end

  // Per-channel state and ring valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_tab[i]     <= '0;
        last_lvl[i]   <= '0;
        stored_avg[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        wp_tab[ci]    <= wp_next;
        last_lvl[ci]  <= level;
        vbit[wr_addr] <= 1'b1;
      end
      if (cmd.out_load && enough) begin
        stored_avg[ci] <= avg_now;
      end
    end
  end

  // Request capture and per-request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r   <= in_channel;
      ok_r   <= in_sensor_ok;
      dist_r <= in_distance;
    end
    if (cmd.commit) begin
      level_r   <= level;
      lvl_chg_r <= (level != last_lvl[ci]);
      rd_idx    <= wp_next;
      scan_k    <= '0;
    end else if (cmd.scan) begin
      rd_idx <= rd_prev;
      scan_k <= scan_k + 1'b1;
    end
  end

  // Ring memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ring_mem[wr_addr] <= level;
    end
    if (cmd.scan) begin
      rd_data <= ring_mem[rd_addr];
      rd_vld  <= vbit[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
    end
  end

  // Window accumulators over nonzero samples
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sum <= '0;
      cnt <= '0;
      hi  <= '0;
      lo  <= tmlf_pkg::LVL_MAX;
    end else if (rd_pend && (smp != '0)) begin
      sum <= sum + SUM_W'(smp);
      cnt <= cnt + 1'b1;
      if (smp > hi) begin
        hi <= smp;
      end
      if (smp < lo) begin
        lo <= smp;
      end
    end
  end

  tmlf_div #(
    .N_W (SUM_W),
    .D_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (numer),
    .denom (cnt - CNT_W'(2)),
    .done  (div_done),
    .quot  (quot)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {avg_now, level_r};
      m_tuser <= {chg_now, enough, ch_r};
    end
  end

endmodule

`default_nettype wire

/* design/tmlf_ctrl.sv */
// ----------------------------------------------------------------------------
// tmlf_ctrl: sequencer for the trimmed mean level filter
// Steps one request through capture, ring write, window scan, optional
// division and output load; a request on an unsupported channel is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tmlf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire tmlf_pkg::tmlf_sts_t sts,
  output tmlf_pkg::tmlf_cmd_t      cmd
);

  typedef enum logic [2:0] {
    IDLE,
    LEVEL,
    SCAN,
    DRAIN,
    DECIDE,
    DIVIDE,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = LEVEL;
        end
      end
      LEVEL: begin
        // unsupported channel: drop the request
        if (sts.ch_ok) begin
          cmd.commit = 1'b1;
          state_next = SCAN;
        end else begin
          state_next = IDLE;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        state_next = DECIDE;
      end
      DECIDE: begin
        if (sts.enough) begin
          cmd.div_start = 1'b1;
          state_next    = DIVIDE;
        end else begin
          state_next = FINISH;
        end
      end
      DIVIDE: begin
        if (sts.div_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* design/trimmed_mean_level_filter.sv */
// ----------------------------------------------------------------------------
// trimmed_mean_level_filter: per-tank level with trimmed mean smoothing
// A request passes capture, ring write, window scan, drain and decide, then
// the divider when an average forms, then the output load. One request at a
// time; the window scan through the single ring read port and the
// 2-bit-per-cycle divider set the rate.
// A request on an unsupported channel is dropped in the LEVEL state.
// Reset clears config, rings (per-entry valid bits), pointers and history.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_level_filter #(
  parameter int RING_DEPTH = 10,
  parameter int WINDOW     = 7,
  parameter int CHANNELS   = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [tmlf_pkg::LVL_W-1:0]      s_tdata,   // [15:0] distance
  input  wire logic [tmlf_pkg::CH_W:0]         s_tuser,   // [1:0] channel, [2] sensor_ok
  // result channel
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [2*tmlf_pkg::LVL_W-1:0]         m_tdata,   // [15:0] level, [31:16] average
  output logic [tmlf_pkg::CH_W+1:0]            m_tuser,   // [1:0] out_channel,
                                                          // [2] average_valid, [3] changed
  // config write port
  input  wire logic                            cfg_we,
  input  wire logic [tmlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmlf_pkg::LVL_W-1:0]      cfg_data
);

  tmlf_pkg::tmlf_cmd_t cmd;
  tmlf_pkg::tmlf_sts_t sts;

  tmlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmlf_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .WINDOW     (WINDOW),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_channel   (s_tuser[tmlf_pkg::CH_W-1:0]),
    .in_sensor_ok (s_tuser[tmlf_pkg::CH_W]),
    .in_distance  (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );

  // Output register is only loaded when empty or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");

  // One request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request accepted while busy");

  // Invalid average always reports zero
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[tmlf_pkg::CH_W]) |->
      (m_tdata[2*tmlf_pkg::LVL_W-1:tmlf_pkg::LVL_W] == '0))
    else $error("nonzero average without valid flag");

  // Divider only launched with a valid sample count
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (sts.enough && sts.ch_ok))
    else $error("divider started without enough samples");

endmodule

`default_nettype wire
